>>> rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

>>> rtl/grr_pkg.sv
`timescale 1ns / 1ps
package grr_pkg;
    localparam int GLYPH_COUNT  = 256;
    localparam int STRIKE_BYTES = 65536;
    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_RUN      = 64;
    localparam int GA_W = $clog2(GLYPH_COUNT);
    localparam int SA_W = $clog2(STRIKE_BYTES);

    localparam logic [1:0] ACT_GLYPH  = 2'd0;
    localparam logic [1:0] ACT_STRIKE = 2'd1;
    localparam logic [1:0] ACT_DRAW   = 2'd2;

    localparam logic [2:0] REG_LOW   = 3'd0;
    localparam logic [2:0] REG_HIGH  = 3'd1;
    localparam logic [2:0] REG_HGT   = 3'd2;
    localparam logic [2:0] REG_FIXW  = 3'd3;
    localparam logic [2:0] REG_MOD   = 3'd4;
    localparam logic [2:0] REG_PROP  = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GLYPH = 6'b000010,
        S_SETUP = 6'b000100,
        S_FETCH = 6'b001000,
        S_SHIFT = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;
endpackage

>>> rtl/glyph_row_renderer_core.sv
`timescale 1ns / 1ps
// glyph row renderer
// input channel: i_in_valid / o_in_stall, one word per load or draw command.
// a glyph load or strike byte load gives no output, so loads can
// follow back to back.
// a draw reads the glyph entry and then builds each font line one pixel
// at a time through a single strike byte port, with an extra read wait
// for each new strike byte it touches; the input is held until the last
// line of the draw is loaded into the output register.
// an out-of-range character gives one word with last set and all else zero.
// output channel: o_out_valid / i_out_stall; a row word is held in the
// output register while stalled, the next line is built meanwhile and is
// loaded once that word is taken. o_in_stall is high while a draw is in work.
// config: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data; always
// ready, write only while idle.
// reset (synchronous, active low) returns registers to defaults and
// drops any word in work; both memories are undefined until loaded.
module glyph_row_renderer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [13:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_address,
    input  logic [15:0]        i_bit_offset,
    input  logic [15:0]        i_bit_run,
    input  logic signed [15:0] i_spacing,
    input  logic signed [15:0] i_kerning,
    input  logic [7:0]         i_data_byte,
    input  logic [7:0]         i_char_code,
    input  logic signed [14:0] i_pos_x,
    input  logic signed [14:0] i_pos_y,
    input  logic [15:0]        i_fg_color,
    input  logic [15:0]        i_bg_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_drawn,
    output logic signed [15:0] o_row_x,
    output logic signed [15:0] o_row_y,
    output logic [6:0]         o_row_width,
    output logic [63:0]        o_row_mask,
    output logic               o_opaque,
    output logic [14:0]        o_left_fill,
    output logic [15:0]        o_right_fill,
    output logic [15:0]        o_pixel_fg,
    output logic [15:0]        o_pixel_bg,
    output logic signed [16:0] o_advance,
    output logic               o_last
);
    grr_pkg::t_state r_state;

    logic [7:0]  r_low, r_high, r_fixw;
    logic [5:0]  r_hgt;
    logic [13:0] r_mod;
    logic        r_prop;

    logic [7:0]  r_char;
    logic [14:0] r_px, r_py;
    logic [15:0] r_fg, r_bg;
    logic [15:0] r_boff;
    logic [6:0]  r_width;
    logic signed [15:0] r_kern;
    logic signed [16:0] r_space;
    logic [5:0]  r_lines, r_line;
    logic [20:0] r_base;
    logic [6:0]  r_pix;
    logic [63:0] r_mask;
    logic [7:0]  r_byte;
    logic [20:0] r_fetched;
    logic        r_oob;
    logic        r_wait;

    logic        r_ov;
    logic        r_drawn, r_opq, r_last;
    logic [15:0] r_rx, r_ry, r_rfill;
    logic [14:0] r_lfill;
    logic [6:0]  r_ow;
    logic [63:0] r_omask;
    logic [16:0] r_adv;
    logic [15:0] r_ofg, r_obg;

    logic        accept;
    logic        out_load;
    logic        g_we, s_we;
    logic [63:0] g_rdata;
    logic [7:0]  s_rdata;
    logic [grr_pkg::GA_W-1:0] g_raddr;
    logic [grr_pkg::SA_W-1:0] s_addr;
    logic [20:0] bit_pos;
    logic [20:0] byte_addr;
    logic        in_range;
    logic [7:0]  gidx;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != grr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_range    = (r_char >= r_low) && (r_char <= r_high);
    assign gidx        = r_char - r_low;
    assign g_raddr     = gidx[grr_pkg::GA_W-1:0];
    assign g_we        = accept && i_action == grr_pkg::ACT_GLYPH
                         && {16'd0, i_address} < 32'(grr_pkg::GLYPH_COUNT);
    assign s_we        = accept && i_action == grr_pkg::ACT_STRIKE
                         && {16'd0, i_address} < 32'(grr_pkg::STRIKE_BYTES);
    assign bit_pos     = {5'd0, r_boff} + {14'd0, r_pix};
    assign byte_addr   = r_base + {3'd0, bit_pos[20:3]};
    assign s_addr      = s_we ? i_address[grr_pkg::SA_W-1:0]
                              : byte_addr[grr_pkg::SA_W-1:0];
    assign out_load    = (!r_ov || !i_out_stall)
                         && ((r_state == grr_pkg::S_SETUP && !in_range)
                             || r_state == grr_pkg::S_OUT);

    grr_ram #(.WIDTH(64), .DEPTH(grr_pkg::GLYPH_COUNT)) u_glyph (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(i_address[grr_pkg::GA_W-1:0]),
        .i_wdata({i_kerning, i_spacing, i_bit_run, i_bit_offset}),
        .i_raddr(g_raddr),
        .o_rdata(g_rdata)
    );

    grr_ram #(.WIDTH(8), .DEPTH(grr_pkg::STRIKE_BYTES)) u_strike (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(i_address[grr_pkg::SA_W-1:0]),
        .i_wdata(i_data_byte),
        .i_raddr(s_addr),
        .o_rdata(s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= 8'd32; r_high <= 8'd126; r_hgt <= 6'd8;
            r_fixw <= 8'd8; r_mod <= 14'd96; r_prop <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                grr_pkg::REG_LOW:  r_low  <= i_cfg_data[7:0];
                grr_pkg::REG_HIGH: r_high <= i_cfg_data[7:0];
                grr_pkg::REG_HGT:  r_hgt  <= i_cfg_data[5:0];
                grr_pkg::REG_FIXW: r_fixw <= i_cfg_data[7:0];
                grr_pkg::REG_MOD:  r_mod  <= i_cfg_data;
                grr_pkg::REG_PROP: r_prop <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grr_pkg::S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            unique case (r_state)
                grr_pkg::S_IDLE: begin
                    if (accept && i_action == grr_pkg::ACT_DRAW) begin
                        r_char <= i_char_code;
                        r_px <= i_pos_x; r_py <= i_pos_y;
                        r_fg <= i_fg_color; r_bg <= i_bg_color;
                        r_state <= grr_pkg::S_GLYPH;
                    end
                end
                grr_pkg::S_GLYPH: begin
                    r_state <= grr_pkg::S_SETUP;
                end
                grr_pkg::S_SETUP: begin
                    if (!in_range) begin
                        if (out_load) begin
                            r_drawn <= 1'b0; r_rx <= '0; r_ry <= '0; r_ow <= '0;
                            r_omask <= '0; r_opq <= 1'b0; r_lfill <= '0;
                            r_rfill <= '0; r_ofg <= '0; r_obg <= '0;
                            r_adv <= '0; r_last <= 1'b1;
                            r_state <= grr_pkg::S_IDLE;
                        end
                    end else begin
                        r_boff <= g_rdata[15:0];
                        r_width <= (g_rdata[31:16] > 16'(grr_pkg::MAX_RUN))
                                   ? 7'(grr_pkg::MAX_RUN) : g_rdata[22:16];
                        if (r_prop) begin
                            r_space <= {g_rdata[47], g_rdata[47:32]};
                            r_kern  <= g_rdata[63:48];
                        end else begin
                            r_space <= {9'd0, r_fixw};
                            r_kern  <= '0;
                        end
                        if (r_hgt == 6'd0) begin
                            r_lines <= 6'd1;
                        end else if (r_hgt > 6'(grr_pkg::MAX_HEIGHT)) begin
                            r_lines <= 6'(grr_pkg::MAX_HEIGHT);
                        end else begin
                            r_lines <= r_hgt;
                        end
                        r_line <= '0; r_base <= '0; r_pix <= '0; r_mask <= '0;
                        r_fetched <= '1; r_wait <= 1'b0;
                        r_state <= grr_pkg::S_FETCH;
                    end
                end
                grr_pkg::S_FETCH: begin
                    // one pixel per step, a new byte read when crossing a byte
                    if (r_pix == r_width) begin
                        r_state <= grr_pkg::S_OUT;
                    end else if (byte_addr == r_fetched && !r_wait) begin
                        r_state <= grr_pkg::S_SHIFT;
                    end else if (r_wait) begin
                        r_byte <= s_rdata;
                        r_oob <= (byte_addr >= 21'(grr_pkg::STRIKE_BYTES));
                        r_fetched <= byte_addr;
                        r_wait <= 1'b0;
                        r_state <= grr_pkg::S_SHIFT;
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                grr_pkg::S_SHIFT: begin
                    if (!r_oob && r_byte[3'd7 - bit_pos[2:0]]) begin
                        r_mask[r_pix[5:0]] <= 1'b1;
                    end
                    r_pix <= r_pix + 7'd1;
                    r_state <= grr_pkg::S_FETCH;
                end
                grr_pkg::S_OUT: begin
                    if (out_load) begin
                        r_drawn <= 1'b1;
                        r_rx <= 16'({r_px[14], r_px} + r_kern);
                        r_ry <= 16'({r_py[14], r_py} + {10'd0, r_line});
                        r_ow <= r_width;
                        r_omask <= r_mask;
                        r_opq <= (r_fg != r_bg);
                        r_lfill <= (r_fg != r_bg && r_kern > 0) ? r_kern[14:0] : '0;
                        r_rfill <= (r_fg != r_bg && r_space > $signed({10'd0, r_width}))
                                   ? 16'(r_space - $signed({10'd0, r_width})) : '0;
                        r_ofg <= r_fg; r_obg <= r_bg;
                        r_adv <= 17'(r_space + {r_kern[15], r_kern});
                        r_last <= (r_line + 6'd1 == r_lines);
                        r_line <= r_line + 6'd1;
                        r_base <= r_base + {7'd0, r_mod};
                        r_pix <= '0; r_mask <= '0; r_fetched <= '1;
                        r_state <= (r_line + 6'd1 == r_lines) ? grr_pkg::S_IDLE
                                                              : grr_pkg::S_FETCH;
                    end
                end
                default: r_state <= grr_pkg::S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_drawn      = r_drawn;
    assign o_row_x      = r_rx;
    assign o_row_y      = r_ry;
    assign o_row_width  = r_ow;
    assign o_row_mask   = r_omask;
    assign o_opaque     = r_opq;
    assign o_left_fill  = r_lfill;
    assign o_right_fill = r_rfill;
    assign o_pixel_fg   = r_ofg;
    assign o_pixel_bg   = r_obg;
    assign o_advance    = r_adv;
    assign o_last       = r_last;
endmodule

>>> rtl/grr_ram.sv
`timescale 1ns / 1ps
module grr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/grr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_drawn,
    input logic        o_last,
    input logic [63:0] o_row_mask,
    input logic [6:0]  o_row_width
)
;
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `CHK_IMPL(a_undrawn_last, i_clk, i_rst_n, o_out_valid && !o_drawn, o_last)
    `CHK_IMPL(a_width, i_clk, i_rst_n, o_out_valid, o_row_width <= 7'd64)
    `CHK_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && o_out_valid
              && i_out_stall, o_out_valid)
endmodule

bind glyph_row_renderer_core grr_checker u_chk (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         action;
        logic [15:0]        address;
        logic [15:0]        bit_offset;
        logic [15:0]        bit_run;
        logic signed [15:0] spacing;
        logic signed [15:0] kerning;
        logic [7:0]         data_byte;
        logic [7:0]         char_code;
        logic signed [14:0] pos_x;
        logic signed [14:0] pos_y;
        logic [15:0]        fg;
        logic [15:0]        bg;
    } t_cmd;

    typedef struct {
        logic        drawn;
        logic [15:0] row_x;
        logic [15:0] row_y;
        logic [6:0]  width;
        logic [63:0] mask;
        logic        opaque;
        logic [14:0] lfill;
        logic [15:0] rfill;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [16:0] advance;
        logic        last;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [13:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_action = '0;
    logic [15:0]        i_address = '0;
    logic [15:0]        i_bit_offset = '0;
    logic [15:0]        i_bit_run = '0;
    logic signed [15:0] i_spacing = '0;
    logic signed [15:0] i_kerning = '0;
    logic [7:0]         i_data_byte = '0;
    logic [7:0]         i_char_code = '0;
    logic signed [14:0] i_pos_x = '0;
    logic signed [14:0] i_pos_y = '0;
    logic [15:0]        i_fg_color = '0;
    logic [15:0]        i_bg_color = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_drawn;
    logic signed [15:0] o_row_x;
    logic signed [15:0] o_row_y;
    logic [6:0]         o_row_width;
    logic [63:0]        o_row_mask;
    logic               o_opaque;
    logic [14:0]        o_left_fill;
    logic [15:0]        o_right_fill;
    logic [15:0]        o_pixel_fg;
    logic [15:0]        o_pixel_bg;
    logic signed [16:0] o_advance;
    logic               o_last;

    glyph_row_renderer_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // block state as predicted
    logic [63:0] glyph_mem [grr_pkg::GLYPH_COUNT];
    logic [7:0]  strike_mem [grr_pkg::STRIKE_BYTES];
    bit          glyph_known [grr_pkg::GLYPH_COUNT];
    bit          strike_known [grr_pkg::STRIKE_BYTES];
    logic [7:0]  low_char = 8'd32;
    logic [7:0]  high_char = 8'd126;
    logic [5:0]  font_height = 6'd8;
    logic [7:0]  fixed_width = 8'd8;
    logic [13:0] row_modulo = 14'd96;
    logic        proportional = 1'b0;

    t_row expected_rows[$];
    int   errors = 0;
    int   rows_checked = 0;
    int   draws_sent = 0;
    int   loads_sent = 0;
    bit   quiet = 1'b0;

    // expected row words of one draw
    function automatic void render_draw(t_cmd c);
        t_row        r;
        int          g, space, kern, width, lines, boff, bitpos;
        int unsigned addr;
        logic [63:0] e;
        r = '{default: '0};
        if (c.char_code < low_char || c.char_code > high_char) begin
            r.last = 1'b1;
            expected_rows.push_back(r);
            return;
        end
        g = int'(c.char_code) - int'(low_char);
        e = glyph_mem[g];
        boff = int'(e[15:0]);
        width = (int'(e[31:16]) > grr_pkg::MAX_RUN) ? grr_pkg::MAX_RUN : int'(e[31:16]);
        space = int'(fixed_width);
        kern = 0;
        if (proportional) begin
            space = int'($signed(e[47:32]));
            kern = int'($signed(e[63:48]));
        end
        lines = (font_height == 6'd0) ? 1 : int'(font_height);
        if (lines > grr_pkg::MAX_HEIGHT) lines = grr_pkg::MAX_HEIGHT;
        r.drawn = 1'b1;
        r.opaque = (c.fg != c.bg);
        if (r.opaque) begin
            if (kern > 0) r.lfill = 15'(kern);
            if (space > width) r.rfill = 16'(space - width);
        end
        r.row_x = 16'(c.pos_x + kern);
        r.width = 7'(width);
        r.fg = c.fg;
        r.bg = c.bg;
        r.advance = 17'(space + kern);
        for (int line = 0; line < lines; line++) begin
            r.row_y = 16'(c.pos_y + line);
            r.mask = '0;
            for (int p = 0; p < width; p++) begin
                bitpos = boff + p;
                addr = int'(row_modulo) * line + (bitpos >> 3);
                if (addr < grr_pkg::STRIKE_BYTES)
                    r.mask[p] = strike_mem[addr][7 - (bitpos & 7)];
            end
            r.last = (line == lines - 1);
            expected_rows.push_back(r);
        end
    endfunction

    function automatic void absorb_word(t_cmd c);
        case (c.action)
            grr_pkg::ACT_GLYPH: if (c.address < grr_pkg::GLYPH_COUNT) begin
                glyph_mem[c.address] = {c.kerning, c.spacing, c.bit_run, c.bit_offset};
                glyph_known[c.address] = 1'b1;
            end
            grr_pkg::ACT_STRIKE: begin
                strike_mem[c.address] = c.data_byte;
                strike_known[c.address] = 1'b1;
            end
            grr_pkg::ACT_DRAW: render_draw(c);
            default: ;
        endcase
    endfunction

    task automatic send_word(t_cmd c);
        int gap;
        i_in_valid <= 1'b1;
        i_action <= c.action;
        i_address <= c.address;
        i_bit_offset <= c.bit_offset;
        i_bit_run <= c.bit_run;
        i_spacing <= c.spacing;
        i_kerning <= c.kerning;
        i_data_byte <= c.data_byte;
        i_char_code <= c.char_code;
        i_pos_x <= c.pos_x;
        i_pos_y <= c.pos_y;
        i_fg_color <= c.fg;
        i_bg_color <= c.bg;
        do @(posedge i_clk); while (o_in_stall);
        absorb_word(c);
        if (c.action == grr_pkg::ACT_DRAW) draws_sent++;
        else loads_sent++;
        gap = 0;
        if (!quiet) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9: gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 3);
            endcase
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_cmd blank_word(logic [1:0] act);
        t_cmd c;
        c = '{default: '0};
        c.action = act;
        return c;
    endfunction

    function automatic t_cmd rand_glyph(logic [15:0] addr);
        t_cmd c;
        c = blank_word(grr_pkg::ACT_GLYPH);
        c.address = addr;
        c.bit_offset = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 63))
                                                   : 16'($urandom);
        case ($urandom_range(0, 9))
            0: c.bit_run = 16'($urandom);
            1, 2: c.bit_run = 16'($urandom_range(17, 64));
            default: c.bit_run = 16'($urandom_range(0, 16));
        endcase
        c.spacing = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 40) - 10);
        c.kerning = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 8) - 4);
        return c;
    endfunction

    function automatic t_cmd make_draw(logic [7:0] ch);
        t_cmd c;
        c = blank_word(grr_pkg::ACT_DRAW);
        c.char_code = ch;
        c.pos_x = 15'($urandom);
        c.pos_y = 15'($urandom);
        c.fg = 16'($urandom);
        c.bg = ($urandom_range(0, 3) == 0) ? c.fg : 16'($urandom);
        return c;
    endfunction

    // load any glyph entry or strike byte this draw would read
    task automatic load_for_draw(logic [7:0] ch);
        t_cmd        c;
        int          g, width, lines, boff;
        int unsigned addr;
        if (ch < low_char || ch > high_char) return;
        g = int'(ch) - int'(low_char);
        if (!glyph_known[g]) send_word(rand_glyph(16'(g)));
        boff = int'(glyph_mem[g][15:0]);
        width = (int'(glyph_mem[g][31:16]) > grr_pkg::MAX_RUN) ? grr_pkg::MAX_RUN
                                                               : int'(glyph_mem[g][31:16]);
        lines = (font_height == 6'd0) ? 1 : int'(font_height);
        if (lines > grr_pkg::MAX_HEIGHT) lines = grr_pkg::MAX_HEIGHT;
        for (int line = 0; line < lines; line++)
            for (int p = 0; p < width; p++) begin
                addr = int'(row_modulo) * line + ((boff + p) >> 3);
                if (addr < grr_pkg::STRIKE_BYTES && !strike_known[addr]) begin
                    c = blank_word(grr_pkg::ACT_STRIKE);
                    c.address = 16'(addr);
                    c.data_byte = 8'($urandom);
                    send_word(c);
                end
            end
    endtask

    task automatic draw_char(t_cmd c);
        load_for_draw(c.char_code);
        send_word(c);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [13:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            grr_pkg::REG_LOW:  low_char = value[7:0];
            grr_pkg::REG_HIGH: high_char = value[7:0];
            grr_pkg::REG_HGT:  font_height = value[5:0];
            grr_pkg::REG_FIXW: fixed_width = value[7:0];
            grr_pkg::REG_MOD:  row_modulo = value;
            grr_pkg::REG_PROP: proportional = value[0];
            default: ;
        endcase
    endtask

    task automatic set_font(int lo, int hi, int hgt, int fw, int md, int prop);
        wait_drained();
        write_reg(grr_pkg::REG_LOW, 14'(lo));
        write_reg(grr_pkg::REG_HIGH, 14'(hi));
        write_reg(grr_pkg::REG_HGT, 14'(hgt));
        write_reg(grr_pkg::REG_FIXW, 14'(fw));
        write_reg(grr_pkg::REG_MOD, 14'(md));
        write_reg(grr_pkg::REG_PROP, 14'(prop));
    endtask

    task automatic test_directed_loads_and_draws();
        t_cmd c;
        c = blank_word(grr_pkg::ACT_GLYPH);
        c.address = 16'd0;
        c.bit_offset = 16'hFFFF;
        c.bit_run = 16'hFFFF;
        c.spacing = -16'sd32768;
        c.kerning = 16'sd32767;
        send_word(c);
        c.address = 16'd33;
        c.bit_offset = 16'd0;
        c.bit_run = 16'd8;
        c.spacing = 16'sd10;
        c.kerning = -16'sd2;
        send_word(c);
        c.address = 16'd94;
        c.bit_offset = 16'd3;
        c.bit_run = 16'd0;
        c.spacing = 16'sd32767;
        c.kerning = -16'sd32768;
        send_word(c);
        c.address = 16'hFFFF;
        send_word(c);
        c.address = 16'(grr_pkg::GLYPH_COUNT);
        send_word(c);
        c = blank_word(grr_pkg::ACT_STRIKE);
        c.address = 16'd0;
        c.data_byte = 8'hFF;
        send_word(c);
        c.address = 16'hFFFF;
        c.data_byte = 8'h80;
        send_word(c);
        c.address = 16'h5555;
        c.data_byte = 8'h07;
        send_word(c);
        send_word(blank_word(ACT_UNUSED));
        c = make_draw(8'd0);
        draw_char(c);
        c.char_code = 8'd255;
        draw_char(c);
        c = make_draw(8'd65);
        c.bg = c.fg;
        draw_char(c);
        c = make_draw(8'd65);
        c.pos_x = -15'sd16384;
        c.pos_y = 15'sd16383;
        c.fg = 16'hFFFF;
        c.bg = 16'h0000;
        draw_char(c);
        c.char_code = 8'd32;
        c.pos_x = 15'sd16383;
        c.pos_y = -15'sd16384;
        draw_char(c);
        c.char_code = 8'd126;
        draw_char(c);
    endtask

    task automatic test_proportional_extremes();
        t_cmd c;
        set_font(32, 126, 32, 255, 8192, 1);
        c = make_draw(8'd32);
        c.pos_x = 15'sd16383;
        c.fg = 16'h1234;
        c.bg = 16'h4321;
        draw_char(c);
        c.char_code = 8'd126;
        draw_char(c);
        c.char_code = 8'd65;
        c.pos_x = -15'sd16384;
        draw_char(c);
        // idle pressure: hold input until every row is back
        wait_drained();
        c.bg = c.fg;
        draw_char(c);
    endtask

    // budget counts every input word, loads included
    task automatic run_random_phase(int budget);
        t_cmd c;
        int   pick;
        int   start;
        start = draws_sent + loads_sent;
        while (draws_sent + loads_sent - start < budget) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                if (low_char <= high_char && $urandom_range(0, 9) != 0)
                    c = make_draw(8'($urandom_range(low_char, high_char)));
                else
                    c = make_draw(8'($urandom));
                draw_char(c);
            end else if (pick < 15) begin
                send_word(rand_glyph(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                  : 16'($urandom_range(0, 255))));
            end else if (pick < 19) begin
                c = blank_word(grr_pkg::ACT_STRIKE);
                c.address = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1023));
                c.data_byte = 8'($urandom);
                send_word(c);
            end else begin
                c = rand_glyph(16'($urandom));
                c.action = ACT_UNUSED;
                c.char_code = 8'($urandom);
                send_word(c);
            end
        end
    endtask

    task automatic test_config_sweep();
        set_font(0, 255, 1, 0, 1, 1);
        run_random_phase(40);
        set_font(10, 5, 8, 8, 96, 1);
        run_random_phase(16);
        set_font(0, 255, 0, 7, 13, 0);
        quiet = 1'b1;
        run_random_phase(40);
        quiet = 1'b0;
        set_font(100, 200, 63, 3, 8192, 1);
        run_random_phase(12);
        set_font(32, 126, 32, 255, 8192, 0);
        run_random_phase(12);
        for (int ph = 0; ph < 5; ph++) begin
            set_font(int'($urandom_range(0, 64)), int'($urandom_range(64, 255)),
                     int'($urandom_range(1, 8)), int'($urandom_range(0, 255)),
                     int'($urandom_range(1, 200)), int'($urandom_range(0, 1)));
            run_random_phase(24);
        end
    endtask

    // output stall pattern: bursts, mostly short, a few long
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_left <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 60))
                                                        : int'($urandom_range(0, 3));
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row word, row_y %h", $time, o_row_y);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                rows_checked++;
                check_field("drawn", 64'(e.drawn), 64'(o_drawn));
                check_field("row_x", 64'(e.row_x), 64'($unsigned(o_row_x)));
                check_field("row_y", 64'(e.row_y), 64'($unsigned(o_row_y)));
                check_field("row_width", 64'(e.width), 64'(o_row_width));
                check_field("row_mask", e.mask, o_row_mask);
                check_field("opaque", 64'(e.opaque), 64'(o_opaque));
                check_field("left_fill", 64'(e.lfill), 64'(o_left_fill));
                check_field("right_fill", 64'(e.rfill), 64'(o_right_fill));
                check_field("pixel_fg", 64'(e.fg), 64'(o_pixel_fg));
                check_field("pixel_bg", 64'(e.bg), 64'(o_pixel_bg));
                check_field("advance", 64'(e.advance), 64'($unsigned(o_advance)));
                check_field("last", 64'(e.last), 64'(o_last));
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d rows outstanding", $time, expected_rows.size());
            $display("glyph_row_renderer_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_loads_and_draws();
        test_proportional_extremes();
        test_config_sweep();
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("covered %0d draws and %0d loads over 12 font settings", draws_sent, loads_sent);
        $display("checked %0d row words, %0d mismatches", rows_checked, errors);
        if (errors == 0 && expected_rows.size() == 0)
            $display("glyph_row_renderer_core verification clean");
        else
            $display("glyph_row_renderer_core verification failed");
        $finish;
    end
endmodule
